[src/sm4e_pkg.sv]
// Package for the SM4 block-mode engine: mode codes, command and status
// types, and the SM4 S-box, tau and linear transforms. No dependencies.
package sm4e_pkg;

	localparam int ROUNDS_DEF = 32;
	localparam int BLOCK_BYTES = 16;
	localparam int CTR_OFFSET = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [2:0] MODE_ECB = 3'd0;
	localparam logic [2:0] MODE_CBC = 3'd1;
	localparam logic [2:0] MODE_CTR = 3'd2;
	localparam logic [2:0] MODE_OFB = 3'd3;
	localparam logic [2:0] MODE_CFB = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENCRYPT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HI  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IV_HI   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IV_LO   = 3'd5;

	// Kind of the current mode as seen by the controller
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_BLOCK  = 2'd1;
	localparam logic [1:0] KIND_STREAM = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYEXP,
		ST_CIPHER,
		ST_FINISH,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic restart;   // latch iv into chain, clear keystream and position
		logic key_start; // load key schedule registers
		logic key_step;  // one key schedule round
		logic take_byte; // store the accepted byte
		logic blk_start; // load cipher state
		logic blk_step;  // one cipher round
		logic blk_done;  // commit cipher result
		logic stream_out; // produce stream byte
		logic emit_next; // advance emit pointer
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;  // 0 none, 1 block, 2 stream
		logic       need_cipher;
	} stat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	localparam logic [31:0] FK0 = 32'ha3b1bac6;
	localparam logic [31:0] FK1 = 32'h56aa3350;
	localparam logic [31:0] FK2 = 32'h677d9197;
	localparam logic [31:0] FK3 = 32'hb27022dc;

	function automatic logic [31:0] tau(input logic [31:0] x);
		tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	// Cipher round linear transform
	function automatic logic [31:0] lin_c(input logic [31:0] t);
		lin_c = t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
	endfunction

	// Key schedule linear transform
	function automatic logic [31:0] lin_k(input logic [31:0] t);
		lin_k = t ^ rotl(t, 13) ^ rotl(t, 23);
	endfunction

	// CK constant for round i: bytes (4i+j)*7 mod 256
	function automatic logic [31:0] ck(input logic [4:0] i);
		logic [7:0] b0, b1, b2, b3, base;
		base = {1'b0, i, 2'b00};
		b0 = base * 8'd7;
		b1 = (base + 8'd1) * 8'd7;
		b2 = (base + 8'd2) * 8'd7;
		b3 = (base + 8'd3) * 8'd7;
		ck = {b0, b1, b2, b3};
	endfunction

endpackage

[src/sm4e_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module sm4e_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[src/sm4e_ctrl.sv]
// Controller for the SM4 engine: sequences key expansion, cipher rounds
// and result emission. Depends on sm4e_pkg.
module sm4e_ctrl #(
	parameter int ROUNDS = sm4e_pkg::ROUNDS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            in_restart,
	input  sm4e_pkg::stat_t stat,
	input  logic            out_fire,
	output sm4e_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            out_valid,
	output logic            out_last,
	output logic [$clog2(ROUNDS)-1:0] round
);
	import sm4e_pkg::*;

	localparam int RW = $clog2(ROUNDS);

	state_t state_q, state_d;
	logic [RW-1:0] cnt_q;
	logic [3:0] emit_q;
	logic is_block_q;

	assign round = cnt_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_restart) state_d = ST_KEYEXP;
					else if (stat.need_cipher) state_d = ST_CIPHER;
					else if (stat.kind == KIND_STREAM) state_d = ST_EMIT;
				end
			end
			ST_KEYEXP: if (cnt_q == RW'(ROUNDS - 1)) state_d = ST_IDLE;
			ST_CIPHER: if (cnt_q == RW'(ROUNDS - 1)) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_EMIT;
			ST_EMIT: if (out_fire && (!is_block_q || emit_q == 4'd15)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		out_valid = 1'b0;
		out_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.restart = in_fire && in_restart;
				cmd.key_start = in_fire && in_restart;
				cmd.take_byte = in_fire && !in_restart;
				cmd.blk_start = in_fire && !in_restart && stat.need_cipher;
			end
			ST_KEYEXP: cmd.key_step = 1'b1;
			ST_CIPHER: cmd.blk_step = 1'b1;
			ST_FINISH: cmd.blk_done = 1'b1;
			ST_EMIT: begin
				out_valid = 1'b1;
				out_last = !is_block_q || emit_q == 4'd15;
				cmd.emit_next = out_fire;
				cmd.stream_out = out_fire && !is_block_q;
			end
			default: ;
		endcase
	end

	// State, round counter, emit pointer, kind latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			emit_q <= '0;
			is_block_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_KEYEXP || state_q == ST_CIPHER) cnt_q <= cnt_q + RW'(1);
			else cnt_q <= '0;
			if (state_q == ST_IDLE) begin
				emit_q <= '0;
				if (in_fire) is_block_q <= (stat.kind == KIND_BLOCK);
			end else if (cmd.emit_next) emit_q <= emit_q + 4'd1;
		end
	end
endmodule

[src/sm4e_dp.sv]
// Datapath for the SM4 engine: configuration registers, key schedule,
// round-key RAM, cipher round unit, mode registers. Depends on sm4e_pkg, sm4e_ram.
module sm4e_dp #(
	parameter int ROUNDS = sm4e_pkg::ROUNDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sm4e_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [sm4e_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic [7:0]                         data_in,
	input  sm4e_pkg::cmd_t                     cmd,
	input  logic [$clog2(ROUNDS)-1:0]          round,
	output sm4e_pkg::stat_t                    stat,
	output logic [7:0]                         data_out
);
	import sm4e_pkg::*;

	localparam int RW = $clog2(ROUNDS);

	logic [2:0]  mode_q;
	logic        enc_q;
	logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic [127:0] chain_q, ks_q, buf_q, res_q;
	logic [3:0]  pos_q, emit_q;
	logic [127:0] kx_q, x_q;
	logic        dec_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ECB;
			enc_q <= 1'b1;
			key_hi_q <= '0; key_lo_q <= '0; iv_hi_q <= '0; iv_lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODE:    mode_q <= cfg_wdata[2:0];
				REG_ENCRYPT: enc_q <= cfg_wdata[0];
				REG_KEY_HI:  key_hi_q <= cfg_wdata;
				REG_KEY_LO:  key_lo_q <= cfg_wdata;
				REG_IV_HI:   iv_hi_q <= cfg_wdata;
				REG_IV_LO:   iv_lo_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Status for the controller
	logic is_blk, is_strm;
	assign is_blk = (mode_q == MODE_ECB) || (mode_q == MODE_CBC);
	assign is_strm = (mode_q == MODE_CTR) || (mode_q == MODE_OFB) || (mode_q == MODE_CFB);
	always_comb begin
		stat.kind = is_blk ? KIND_BLOCK : (is_strm ? KIND_STREAM : KIND_NONE);
		stat.need_cipher = is_blk ? (pos_q == 4'd15) : (is_strm && pos_q == 4'd0);
	end

	// Key schedule round
	logic [31:0] knew;
	assign knew = kx_q[127:96] ^ lin_k(tau(kx_q[95:64] ^ kx_q[63:32] ^ kx_q[31:0] ^ ck(5'(round))));

	// Round key RAM: registered read, address one round ahead
	logic [RW-1:0] raddr, rsel;
	logic [31:0]   rk;
	always_comb begin
		rsel = cmd.blk_step ? round + RW'(1) : '0;
		raddr = dec_q ? RW'(ROUNDS - 1) - rsel : rsel;
		if (cmd.blk_start) raddr = (!enc_q && mode_q == MODE_ECB) || (!enc_q && mode_q == MODE_CBC)
			? RW'(ROUNDS - 1) : '0;
	end
	sm4e_ram #(.WIDTH(32), .DEPTH(ROUNDS)) u_rk (
		.clk(clk), .we(cmd.key_step), .waddr(round), .wdata(knew),
		.raddr(raddr), .rdata(rk)
	);

	// Cipher round
	logic [31:0] xnew;
	assign xnew = x_q[127:96] ^ lin_c(tau(x_q[95:64] ^ x_q[63:32] ^ x_q[31:0] ^ rk));
	logic [127:0] cres;
	assign cres = {x_q[31:0], x_q[63:32], x_q[95:64], x_q[127:96]};

	// Full block with the incoming 16th byte
	logic [127:0] blk_full;
	always_comb begin
		blk_full = buf_q;
		blk_full[8'(127 - 8 * pos_q) -: 8] = data_in;
	end

	logic [7:0] kbyte;
	assign kbyte = (mode_q == MODE_CTR) ? ks_q[8'(127 - 8 * emit_q) -: 8]
	                                    : chain_q[8'(127 - 8 * emit_q) -: 8];
	logic [7:0] din_q;

	// Output byte selection
	always_comb begin
		if (stat.kind == KIND_BLOCK || !is_strm) data_out = res_q[8'(127 - 8 * emit_q) -: 8];
		else data_out = din_q ^ kbyte;
	end

	// Mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0; ks_q <= '0; pos_q <= '0; emit_q <= '0; dec_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				chain_q <= {iv_hi_q, iv_lo_q};
				ks_q <= '0;
				pos_q <= '0;
			end
			if (cmd.take_byte && (is_blk || is_strm)) begin
				emit_q <= is_blk ? 4'd0 : pos_q;
				if (is_blk) pos_q <= pos_q + 4'd1;
			end
			if (cmd.blk_start) dec_q <= is_blk && !enc_q;
			if (cmd.blk_done) begin
				if (mode_q == MODE_CTR) begin
					ks_q <= cres;
					chain_q[31:0] <= chain_q[31:0] + 32'd1;
				end else if (mode_q == MODE_OFB || mode_q == MODE_CFB) begin
					chain_q <= cres;
				end else if (mode_q == MODE_CBC) begin
					chain_q <= enc_q ? cres : buf_q;
				end
			end
			if (cmd.emit_next && !is_blk) begin
				if (cmd.stream_out) begin
					pos_q <= pos_q + 4'd1;
					if (mode_q == MODE_CFB)
						chain_q[8'(127 - 8 * emit_q) -: 8] <= enc_q ? (din_q ^ kbyte) : din_q;
				end
			end
			if (cmd.emit_next && is_blk) emit_q <= emit_q + 4'd1;
		end
	end

	// Key schedule, block and cipher payload registers
	always_ff @(posedge clk) begin
		if (cmd.key_start)
			kx_q <= {key_hi_q[63:32] ^ FK0, key_hi_q[31:0] ^ FK1,
			         key_lo_q[63:32] ^ FK2, key_lo_q[31:0] ^ FK3};
		else if (cmd.key_step)
			kx_q <= {kx_q[95:0], knew};
		if (cmd.take_byte) begin
			din_q <= data_in;
			if (is_blk) buf_q[8'(127 - 8 * pos_q) -: 8] <= data_in;
		end
		if (cmd.blk_start) begin
			if (is_blk) x_q <= (mode_q == MODE_CBC && enc_q) ? blk_full ^ chain_q : blk_full;
			else x_q <= chain_q;
		end else if (cmd.blk_step)
			x_q <= {x_q[95:0], xnew};
		if (cmd.blk_done)
			res_q <= (mode_q == MODE_CBC && !enc_q) ? cres ^ chain_q : cres;
	end
endmodule

[src/sm4_block_modes_engine_top.sv]
// SM4 block-mode engine, top level (ECB, CBC, CTR, OFB, CFB-128).
// Streams bytes in on s_axis, results out on m_axis; configured via a write port.
// s_axis_tdata: data_in[7:0]; s_axis_tuser: action (1 restart, 0 data).
// m_axis_tdata: data_out[7:0]; m_axis_tlast: last result of the input item.
// Configuration registers 0..5: mode, encrypt, key_hi, key_lo, iv_hi, iv_lo;
// write only while the engine is idle.
// A restart runs the key schedule, one round per cycle; the engine is busy meanwhile.
// ECB/CBC: bytes 1..15 are only buffered; the 16th runs ROUNDS
// cipher rounds and a commit state, then 16 result bytes are sent,
// one per cycle while the receiver is ready.
// Stream modes: a byte at block position 0 first runs the cipher rounds
// for a new keystream block; other bytes give one result in the next cycle.
// All modes share the single cipher round unit.
// s_axis_tready is low while an item is in work or results wait.
// A stalled receiver holds the current result and the input is not taken.
// Reset clears configuration to ECB encrypt, zero key/IV, and all chaining.
module sm4_block_modes_engine_top #(
	parameter int ROUNDS = sm4e_pkg::ROUNDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sm4e_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [sm4e_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata, // data_in[7:0]
	input  logic                             s_axis_tuser, // action
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [7:0]                       m_axis_tdata, // data_out[7:0]
	output logic                             m_axis_tlast
);
	import sm4e_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  busy, in_fire, out_fire;
	logic [$clog2(ROUNDS)-1:0] round;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	sm4e_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_restart(s_axis_tuser),
		.stat(stat), .out_fire(out_fire), .cmd(cmd), .busy(busy),
		.out_valid(m_axis_tvalid), .out_last(m_axis_tlast), .round(round)
	);

	sm4e_dp #(.ROUNDS(ROUNDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .data_in(s_axis_tdata), .cmd(cmd), .round(round),
		.stat(stat), .data_out(m_axis_tdata)
	);

	// No input is taken while a result is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted while output pending");

	// A restart never produces output in the next cycle
	a_restart_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_axis_tuser) |=> !m_axis_tvalid)
		else $error("restart produced output");

	// Last result returns the engine to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_axis_tlast) |=> s_axis_tready)
		else $error("engine busy after last result");
endmodule
